// ===== sv/imu_fall_detector_macros.svh =====
// assertion macros shared by the fall detector rtl
`ifndef IMU_FALL_DETECTOR_MACROS_SVH
`define IMU_FALL_DETECTOR_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define IFD_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("fall detector check failed");

// next-cycle implication
`define IFD_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("fall detector check failed");

`endif

// ===== sv/ifd_pkg.sv =====
// types and constants shared by the fall detector modules
package ifd_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_CONFIRM,
    MODE_FALL,
    MODE_LIE
  } mode_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_MUL_NEW,
    F_MUL_OLD,
    F_DIV,
    F_SQUARE,
    F_THR_LOW,
    F_THR_ROT,
    F_THR_IMP,
    F_DONE
  } fstate_t;

  typedef enum logic [2:0] {
    REG_ACC_ALPHA,
    REG_GYRO_ALPHA,
    REG_LOW_G,
    REG_ROTATION,
    REG_IMPACT,
    REG_TRIG_HOLD,
    REG_CONFIRM_WIN,
    REG_LIE_HOLD
  } cfg_reg_t;

  localparam int MUL_W  = 24;
  localparam int PROD_W = 48;
  localparam int DIV_W  = 30;
  localparam int NUM_AXES = 6;
  localparam logic [2:0] LAST_AXIS = 3'(NUM_AXES - 1);
  localparam logic [2:0] FIRST_GYRO_AXIS = 3'd3;

  localparam logic [6:0]  ALPHA_FULL    = 7'd100;
  localparam logic [7:0]  DIVISOR       = 8'd100;
  localparam logic [31:0] SETTLE_MS     = 32'd500;
  localparam logic [31:0] PRESS_ACK_MS  = 32'd2000;
  localparam logic [31:0] STILL_MIN_SQ  = 32'd640000;
  localparam logic [31:0] STILL_MAX_SQ  = 32'd1440000;
  localparam logic [47:0] STILL_RATE_SQ = 48'd2500000000;

  typedef struct packed {
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [23:0] rate_x;
    logic signed [23:0] rate_y;
    logic signed [23:0] rate_z;
    logic [31:0]        time_ms;
    logic               button_held;
  } sample_t;

  typedef struct packed {
    logic [6:0]  accel_alpha_pct;
    logic [6:0]  gyro_alpha_pct;
    logic [12:0] low_g_mg;
    logic [21:0] rotation_mdps;
    logic [13:0] impact_mg;
    logic [15:0] trig_hold;
    logic [15:0] confirm_window_ms;
    logic [31:0] lie_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] accel_mag_sq;
    logic [47:0] rate_mag_sq;
    logic [25:0] low_sq;
    logic [43:0] rot_sq;
    logic [27:0] impact_sq;
  } mags_t;

  typedef struct packed {
    mode_t mode;
    logic  fall_event;
    logic  lie_event;
    logic  recover_event;
    logic  alarm;
  } result_t;

endpackage

// ===== sv/ifd_mul.sv =====
// shift-add multiplier, one bit of the multiplier operand per cycle
module ifd_mul
  import ifd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MUL_W-1:0]  x,
  input  logic [MUL_W-1:0]  y,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic              busy;
  logic [PROD_W-1:0] xs;
  logic [MUL_W-1:0]  ys;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xs   <= {{(PROD_W-MUL_W){1'b0}}, x};
        ys   <= y;
        prod <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // finishes as soon as no multiplier bits are left
        if (ys == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (ys[0]) begin
            prod <= prod + xs;
          end
          xs <= xs << 1;
          ys <= ys >> 1;
        end
      end
    end
  end

endmodule

// ===== sv/ifd_div.sv =====
// restoring divide by one hundred, one quotient bit per cycle
module ifd_div
  import ifd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  logic       busy;
  logic [6:0] rem;
  logic [4:0] cnt;
  logic [7:0] trial;
  logic       fits;

  assign trial = {rem, quot[DIV_W-1]};
  assign fits  = trial >= DIVISOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= dividend;
        rem  <= '0;
        cnt  <= 5'(DIV_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        // dividend bits shift out the top while quotient bits shift in
        rem  <= fits ? 7'(trial - DIVISOR) : trial[6:0];
        quot <= {quot[DIV_W-2:0], fits};
        cnt  <= cnt - 5'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/ifd_filter.sv =====
// per-axis ewma filters, squared magnitudes and squared thresholds
module ifd_filter
  import ifd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  sample_t sample,
  input  cfg_t    cfg,
  input  logic    ack,
  output logic    done,
  output mags_t   mags
);

  fstate_t st, st_next;
  logic    pend, pend_next;
  logic    mul_start, div_start;
  logic    mul_done, div_done;
  logic [MUL_W-1:0]  mul_x, mul_y;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  quot;

  logic [2:0]         axis;
  logic signed [31:0] num;
  logic signed [23:0] filt [NUM_AXES];
  logic signed [23:0] new_val, old_val, cur_filt;
  logic [6:0]         alpha_raw, alpha;
  logic [31:0]        num_abs;
  logic [23:0]        q24;
  logic signed [31:0] p32;

  function automatic logic [23:0] mag24(input logic signed [23:0] v);
    mag24 = v[23] ? 24'(-v) : 24'(v);
  endfunction

  always_comb begin
    unique case (axis)
      3'd0:    new_val = {{8{sample.acc_x[15]}}, sample.acc_x};
      3'd1:    new_val = {{8{sample.acc_y[15]}}, sample.acc_y};
      3'd2:    new_val = {{8{sample.acc_z[15]}}, sample.acc_z};
      3'd3:    new_val = sample.rate_x;
      3'd4:    new_val = sample.rate_y;
      3'd5:    new_val = sample.rate_z;
      default: new_val = '0;
    endcase
  end

  assign old_val   = filt[axis];
  assign cur_filt  = filt[axis];
  assign alpha_raw = (axis < FIRST_GYRO_AXIS) ? cfg.accel_alpha_pct : cfg.gyro_alpha_pct;
  assign alpha     = (alpha_raw > ALPHA_FULL) ? ALPHA_FULL : alpha_raw;
  assign num_abs   = num[31] ? 32'(-num) : 32'(num);
  assign q24       = quot[23:0];
  assign p32       = signed'(prod[31:0]);

  always_comb begin
    unique case (st)
      F_MUL_NEW: begin
        mul_x = mag24(new_val);
        mul_y = {17'b0, alpha};
      end
      F_MUL_OLD: begin
        mul_x = mag24(old_val);
        mul_y = {17'b0, 7'(ALPHA_FULL - alpha)};
      end
      F_SQUARE: begin
        mul_x = mag24(cur_filt);
        mul_y = mag24(cur_filt);
      end
      F_THR_LOW: begin
        mul_x = {11'b0, cfg.low_g_mg};
        mul_y = {11'b0, cfg.low_g_mg};
      end
      F_THR_ROT: begin
        mul_x = {2'b0, cfg.rotation_mdps};
        mul_y = {2'b0, cfg.rotation_mdps};
      end
      F_THR_IMP: begin
        mul_x = {10'b0, cfg.impact_mg};
        mul_y = {10'b0, cfg.impact_mg};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  // sequencer: each step launches one unit, then waits for its done pulse
  always_comb begin
    st_next   = st;
    pend_next = pend;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (st)
      F_IDLE: begin
        if (start) begin
          st_next = F_MUL_NEW;
        end
      end
      F_MUL_NEW, F_MUL_OLD, F_SQUARE, F_THR_LOW, F_THR_ROT, F_THR_IMP: begin
        if (!pend) begin
          mul_start = 1'b1;
          pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0;
          unique case (st)
            F_MUL_NEW: st_next = F_MUL_OLD;
            F_MUL_OLD: st_next = F_DIV;
            F_SQUARE:  st_next = (axis == LAST_AXIS) ? F_THR_LOW : F_MUL_NEW;
            F_THR_LOW: st_next = F_THR_ROT;
            F_THR_ROT: st_next = F_THR_IMP;
            default:   st_next = F_DONE;
          endcase
        end
      end
      F_DIV: begin
        if (!pend) begin
          div_start = 1'b1;
          pend_next = 1'b1;
        end else if (div_done) begin
          pend_next = 1'b0;
          st_next   = F_SQUARE;
        end
      end
      F_DONE: begin
        if (ack) begin
          st_next = F_IDLE;
        end
      end
      default: st_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= F_IDLE;
      pend <= 1'b0;
    end else begin
      st   <= st_next;
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        filt[i] <= '0;
      end
      axis <= '0;
    end else begin
      if (st == F_IDLE && start) begin
        axis              <= '0;
        mags.accel_mag_sq <= '0;
        mags.rate_mag_sq  <= '0;
      end
      if (pend && mul_done) begin
        unique case (st)
          F_MUL_NEW: num <= new_val[23] ? -p32 : p32;
          F_MUL_OLD: num <= old_val[23] ? num - p32 : num + p32;
          F_SQUARE: begin
            if (axis < FIRST_GYRO_AXIS) begin
              mags.accel_mag_sq <= mags.accel_mag_sq + prod[31:0];
            end else begin
              mags.rate_mag_sq <= mags.rate_mag_sq + prod;
            end
            axis <= axis + 3'd1;
          end
          F_THR_LOW: mags.low_sq    <= prod[25:0];
          F_THR_ROT: mags.rot_sq    <= prod[43:0];
          F_THR_IMP: mags.impact_sq <= prod[27:0];
          default: ;
        endcase
      end
      if (st == F_DIV && pend && div_done) begin
        // truncation toward zero: divide the magnitude, then restore the sign
        filt[axis] <= num[31] ? -signed'(q24) : signed'(q24);
      end
    end
  end

  assign done = (st == F_DONE);

  ifd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .prod  (prod)
  );

  ifd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_abs[DIV_W-1:0]),
    .done     (div_done),
    .quot     (quot)
  );

endmodule

// ===== sv/ifd_mode.sv =====
// four-mode fall machine with its run timers and acknowledge logic
module ifd_mode
  import ifd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] now,
  input  logic        button,
  input  mags_t       mags,
  input  cfg_t        cfg,
  output result_t     res
);

  mode_t       mode, mode_next;
  logic        settle_valid;
  logic [31:0] settle_start, settle_start_next;
  logic        low_on, low_on_next, spin_on, spin_on_next;
  logic [31:0] low_start, low_start_next, spin_start, spin_start_next;
  logic [31:0] confirm_start, confirm_start_next;
  logic        press_on, press_on_next, quiet_on, quiet_on_next;
  logic [31:0] press_start, press_start_next, quiet_start, quiet_start_next;
  logic [31:0] settle_eff;
  logic        settle_ok, is_low, is_spin, low_hit, spin_hit, still;
  logic        timeout, ack, quiet_hit;
  logic        fall_ev, lie_ev, rec_ev;

  always_comb begin
    settle_eff         = settle_valid ? settle_start : now;
    mode_next          = mode;
    settle_start_next  = settle_eff;
    low_on_next        = low_on;
    low_start_next     = low_start;
    spin_on_next       = spin_on;
    spin_start_next    = spin_start;
    confirm_start_next = confirm_start;
    press_on_next      = press_on;
    press_start_next   = press_start;
    quiet_on_next      = quiet_on;
    quiet_start_next   = quiet_start;
    fall_ev            = 1'b0;
    lie_ev             = 1'b0;
    rec_ev             = 1'b0;

    settle_ok = (now - settle_eff) >= SETTLE_MS;
    is_low    = mags.accel_mag_sq < {6'b0, mags.low_sq};
    is_spin   = mags.rate_mag_sq > {4'b0, mags.rot_sq};
    // a run that starts on this sample has lasted zero
    low_hit   = is_low && (low_on ? (now - low_start) >= {16'b0, cfg.trig_hold}
                                  : cfg.trig_hold == '0);
    spin_hit  = is_spin && (spin_on ? (now - spin_start) >= {16'b0, cfg.trig_hold}
                                    : cfg.trig_hold == '0);
    still     = mags.accel_mag_sq >= STILL_MIN_SQ && mags.accel_mag_sq <= STILL_MAX_SQ &&
                mags.rate_mag_sq < STILL_RATE_SQ;
    ack       = press_on && (now - press_start) > PRESS_ACK_MS;
    quiet_hit = quiet_on ? (now - quiet_start) >= cfg.lie_hold_ms : cfg.lie_hold_ms == '0;

    if (mode == MODE_NORMAL && settle_ok) begin
      low_on_next  = is_low;
      spin_on_next = is_spin;
      if (is_low && !low_on) begin
        low_start_next = now;
      end
      if (is_spin && !spin_on) begin
        spin_start_next = now;
      end
      if (low_hit || spin_hit) begin
        mode_next          = MODE_CONFIRM;
        confirm_start_next = now;
        low_on_next        = 1'b0;
        spin_on_next       = 1'b0;
      end
    end

    timeout = (now - confirm_start_next) >= {16'b0, cfg.confirm_window_ms};
    if (mode_next == MODE_CONFIRM) begin
      if (timeout) begin
        mode_next = MODE_NORMAL;
      end else if (mags.accel_mag_sq >= {4'b0, mags.impact_sq}) begin
        mode_next = MODE_FALL;
        fall_ev   = 1'b1;
      end
    end

    if (mode_next == MODE_FALL || mode_next == MODE_LIE) begin
      if (button) begin
        if (!press_on) begin
          press_start_next = now;
        end
        press_on_next = 1'b1;
        if (ack) begin
          mode_next         = MODE_NORMAL;
          settle_start_next = now;
          press_on_next     = 1'b0;
          quiet_on_next     = 1'b0;
        end
      end else begin
        press_on_next = 1'b0;
      end
    end

    if (mode_next == MODE_FALL) begin
      if (still) begin
        if (!quiet_on) begin
          quiet_start_next = now;
        end
        quiet_on_next = 1'b1;
        if (quiet_hit) begin
          mode_next     = MODE_LIE;
          quiet_on_next = 1'b0;
          lie_ev        = 1'b1;
        end
      end else begin
        quiet_on_next = 1'b0;
      end
    end

    priority if (mode_next == MODE_FALL && mode != MODE_FALL) begin
      press_on_next = 1'b0;
      quiet_on_next = 1'b0;
    end else if (mode_next == MODE_LIE && mode != MODE_LIE) begin
      press_on_next = 1'b0;
    end else if (mode_next == MODE_NORMAL && (mode == MODE_FALL || mode == MODE_LIE)) begin
      rec_ev            = 1'b1;
      settle_start_next = now;
    end else begin
      // no alarm entry or exit on this sample
    end

    res.mode          = mode_next;
    res.fall_event    = fall_ev;
    res.lie_event     = lie_ev;
    res.recover_event = rec_ev;
    res.alarm         = mode_next == MODE_FALL || mode_next == MODE_LIE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_NORMAL;
      settle_valid  <= 1'b0;
      settle_start  <= '0;
      low_on        <= 1'b0;
      low_start     <= '0;
      spin_on       <= 1'b0;
      spin_start    <= '0;
      confirm_start <= '0;
      press_on      <= 1'b0;
      press_start   <= '0;
      quiet_on      <= 1'b0;
      quiet_start   <= '0;
    end else if (go) begin
      mode          <= mode_next;
      settle_valid  <= 1'b1;
      settle_start  <= settle_start_next;
      low_on        <= low_on_next;
      low_start     <= low_start_next;
      spin_on       <= spin_on_next;
      spin_start    <= spin_start_next;
      confirm_start <= confirm_start_next;
      press_on      <= press_on_next;
      press_start   <= press_start_next;
      quiet_on      <= quiet_on_next;
      quiet_start   <= quiet_start_next;
    end
  end

endmodule

// ===== sv/imu_fall_detector.sv =====
// IMU fall detector: one sample in, one status item out. The processing time of
// each sample depends on the operand bits: the six axis filters and squares and
// the three squared thresholds all go through one shared shift-add multiplier
// that retires one multiplier bit per cycle, and each filter output passes
// through a bit-serial divide by one hundred. The next sample is taken once the
// previous status sits in the output register, even if that status has not been
// read yet.
`include "imu_fall_detector_macros.svh"

module imu_fall_detector
  import ifd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, time_ms, button_held, zero fill
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // mode, accel_mag_sq, rate_mag_sq, fall_event, lie_event, recover_event, alarm,
  // zero fill
  output logic [87:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  cfg_t    cfg;
  sample_t sample;
  mags_t   mags;
  result_t res;
  logic    busy, accept, f_done, finish;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy;
  assign accept    = s_tvalid && s_tready;
  assign finish    = f_done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_alpha_pct   <= 7'd50;
      cfg.gyro_alpha_pct    <= 7'd15;
      cfg.low_g_mg          <= 13'd600;
      cfg.rotation_mdps     <= 22'd100000;
      cfg.impact_mg         <= 14'd2400;
      cfg.trig_hold         <= 16'd70;
      cfg.confirm_window_ms <= 16'd1000;
      cfg.lie_hold_ms       <= 32'd30000;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ACC_ALPHA:   cfg.accel_alpha_pct   <= cfg_data[6:0];
        REG_GYRO_ALPHA:  cfg.gyro_alpha_pct    <= cfg_data[6:0];
        REG_LOW_G:       cfg.low_g_mg          <= cfg_data[12:0];
        REG_ROTATION:    cfg.rotation_mdps     <= cfg_data[21:0];
        REG_IMPACT:      cfg.impact_mg         <= cfg_data[13:0];
        REG_TRIG_HOLD:   cfg.trig_hold         <= cfg_data[15:0];
        REG_CONFIRM_WIN: cfg.confirm_window_ms <= cfg_data[15:0];
        REG_LIE_HOLD:    cfg.lie_hold_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample.acc_x       <= s_tdata[15:0];
      sample.acc_y       <= s_tdata[31:16];
      sample.acc_z       <= s_tdata[47:32];
      sample.rate_x      <= s_tdata[71:48];
      sample.rate_y      <= s_tdata[95:72];
      sample.rate_z      <= s_tdata[119:96];
      sample.time_ms     <= s_tdata[151:120];
      sample.button_held <= s_tdata[152];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= {2'b0, res.alarm, res.recover_event, res.lie_event, res.fall_event,
                  mags.rate_mag_sq, mags.accel_mag_sq, res.mode};
    end
  end

  ifd_filter u_filter (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .sample (sample),
    .cfg    (cfg),
    .ack    (finish),
    .done   (f_done),
    .mags   (mags)
  );

  ifd_mode u_mode (
    .clk    (clk),
    .rst    (rst),
    .go     (finish),
    .now    (sample.time_ms),
    .button (sample.button_held),
    .mags   (mags),
    .cfg    (cfg),
    .res    (res)
  );

  `IFD_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready)
  `IFD_ASSERT_NOW(a_alarm_matches_mode, m_tvalid, m_tdata[85] == m_tdata[1])
  `IFD_ASSERT_NOW(a_fall_event_in_alarm, m_tvalid && m_tdata[82], m_tdata[1])
  `IFD_ASSERT_NOW(a_finish_only_when_busy, finish, busy)

endmodule
